// ===== rtl/core/vnc_pkg.sv =====
// ----------------------------------------------------------------------------
// vnc_pkg
// command codes and control bundle shared by the vector norm/cosine unit
// ----------------------------------------------------------------------------
package vnc_pkg;

  typedef enum logic [1:0] {
    CMD_LENGTH    = 2'd0,
    CMD_NORMALIZE = 2'd1,
    CMD_DOT       = 2'd2,
    CMD_COSINE    = 2'd3
  } cmd_e;

  // control that rides alongside the divider
  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] a_neg;
    logic       d_neg;
    logic       zero;
  } ctrl_t;

endpackage

// ===== rtl/core/vnc_delay.sv =====
// ----------------------------------------------------------------------------
// vnc_delay
// fixed-length shift register that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
module vnc_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int k = 1; k < DEPTH; k++) begin
      tap_q[k] <= tap_q[k-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// ===== rtl/core/vnc_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// vnc_sqrt_pipe
// digit-by-digit integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module vnc_sqrt_pipe #(
  parameter int W = 32
) (
  input  logic           clk_i,
  input  logic [2*W-1:0] sq_i,
  output logic [W-1:0]   root_o
);

  localparam int RW = W + 2;
  localparam int SW = W + 4;

  logic [RW-1:0]  rem_q  [0:W-1];
  logic [W-1:0]   root_q [0:W-1];
  logic [2*W-1:0] sq_q   [0:W-1];

  logic [RW-1:0]  rem_in  [0:W-1];
  logic [W-1:0]   root_in [0:W-1];
  logic [2*W-1:0] sq_in   [0:W-1];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [SW-1:0] rem_sh;
    logic [SW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign sq_in[k]   = sq_i;
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign sq_in[k]   = sq_q[k-1];
    end

    // bring down the next two bits of the radicand
    assign rem_sh = {rem_in[k], sq_in[k][2*W-1 -: 2]};
    assign trial  = SW'({root_in[k], 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
      root_q[k] <= {root_in[k][W-2:0], ge};
      sq_q[k]   <= sq_in[k] << 2;
    end
  end

  assign root_o = root_q[W-1];

endmodule

// ===== rtl/core/vnc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// vnc_div_pipe
// restoring unsigned divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module vnc_div_pipe #(
  parameter int NW = 80,
  parameter int DW = 64
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  localparam int RW = DW + 1;

  logic [RW-1:0] rem_q [0:NW];
  logic [NW-1:0] num_q [0:NW];
  logic [NW-1:0] quo_q [0:NW];
  logic [DW-1:0] den_q [0:NW];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    num_q[0] <= num_i;
    quo_q[0] <= '0;
    den_q[0] <= den_i;
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [RW-1:0] rem_sh;
    logic          ge;

    assign rem_sh = {rem_q[k][RW-2:0], num_q[k][NW-1]};
    assign ge     = (rem_sh >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? (rem_sh - {1'b0, den_q[k]}) : rem_sh;
      num_q[k+1] <= num_q[k] << 1;
      quo_q[k+1] <= {quo_q[k][NW-2:0], ge};
      den_q[k+1] <= den_q[k];
    end
  end

  assign quo_o = quo_q[NW];

endmodule

// ===== rtl/core/vector_norm_cosine_unit.sv =====
// ----------------------------------------------------------------------------
// vector_norm_cosine_unit
// length, unit vector, dot product and cosine of 3d vectors in signed q format
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start_i is high; busy_o is never
// raised. Each request gives one result, shown for a single cycle with
// result_valid_o; the receiver cannot hold results back. The pipeline runs
// through the square root, one root bit per stage, and the divider, one
// quotient bit per stage over 2*WORD_BITS+FRAC_BITS bits.
module vector_norm_cosine_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  command_i,
  input  logic signed [WORD_BITS-1:0] vec_a_x_i,
  input  logic signed [WORD_BITS-1:0] vec_a_y_i,
  input  logic signed [WORD_BITS-1:0] vec_a_z_i,
  input  logic signed [WORD_BITS-1:0] vec_b_x_i,
  input  logic signed [WORD_BITS-1:0] vec_b_y_i,
  input  logic signed [WORD_BITS-1:0] vec_b_z_i,
  output logic                        result_valid_o,
  output logic signed [WORD_BITS-1:0] scalar_out_o,
  output logic signed [WORD_BITS-1:0] unit_x_o,
  output logic signed [WORD_BITS-1:0] unit_y_o,
  output logic signed [WORD_BITS-1:0] unit_z_o,
  output logic                        zero_vector_o,
  output logic                        saturated_o
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int NW  = PW + F;
  localparam int LAT = W + NW + 5;
  localparam int CW  = $bits(vnc_pkg::ctrl_t);
  localparam int SDW = 2 + 3 + 3 * W + 2 * PW;
  localparam logic [W-1:0] ONE = W'(1) << F;

  function automatic logic [W:0] clip_word(input logic [NW-1:0] mag, input logic neg);
    logic [NW-1:0] lim;
    logic          sat;
    logic [W-1:0]  val;
    if (neg) begin
      lim = NW'(1) << (W - 1);
      sat = (mag > lim);
      val = sat ? lim[W-1:0] : (~mag[W-1:0] + 1'b1);
    end else begin
      lim = (NW'(1) << (W - 1)) - NW'(1);
      sat = (mag > lim);
      val = sat ? lim[W-1:0] : mag[W-1:0];
    end
    return {sat, val};
  endfunction

  // valid bits
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end

  assign busy_o         = 1'b0;
  assign result_valid_o = vld_q[LAT-1];

  // stage 0: sign and magnitude
  logic [W-1:0] a_in [0:2];
  logic [W-1:0] b_in [0:2];

  assign a_in[0] = vec_a_x_i;
  assign a_in[1] = vec_a_y_i;
  assign a_in[2] = vec_a_z_i;
  assign b_in[0] = vec_b_x_i;
  assign b_in[1] = vec_b_y_i;
  assign b_in[2] = vec_b_z_i;

  vnc_pkg::cmd_e cmd0_q, cmd1_q, cmd2_q;
  logic [W-1:0]  am0_q [0:2];
  logic [W-1:0]  bm0_q [0:2];
  logic [2:0]    an0_q, bn0_q, an1_q, xn1_q, an2_q;
  logic [W-1:0]  am1_q [0:2];
  logic [W-1:0]  am2_q [0:2];
  logic [PW-1:0] sqa1_q [0:2];
  logic [PW-1:0] sqb1_q [0:2];
  logic [PW-1:0] pab1_q [0:2];
  logic [PW-1:0] sa2_q, sb2_q, pos2_q, neg2_q;
  logic [PW-1:0] pos_sum, neg_sum;

  always_ff @(posedge clk_i) begin
    cmd0_q <= vnc_pkg::cmd_e'(command_i);
    for (int k = 0; k < 3; k++) begin
      an0_q[k] <= a_in[k][W-1];
      bn0_q[k] <= b_in[k][W-1];
      am0_q[k] <= a_in[k][W-1] ? (~a_in[k] + 1'b1) : a_in[k];
      bm0_q[k] <= b_in[k][W-1] ? (~b_in[k] + 1'b1) : b_in[k];
    end
  end

  // stage 1: squares and component products
  always_ff @(posedge clk_i) begin
    cmd1_q <= cmd0_q;
    an1_q  <= an0_q;
    xn1_q  <= an0_q ^ bn0_q;
    for (int k = 0; k < 3; k++) begin
      am1_q[k]  <= am0_q[k];
      sqa1_q[k] <= am0_q[k] * am0_q[k];
      sqb1_q[k] <= bm0_q[k] * bm0_q[k];
      pab1_q[k] <= am0_q[k] * bm0_q[k];
    end
  end

  // stage 2: sums of squares, dot product split by sign
  always_comb begin
    pos_sum = '0;
    neg_sum = '0;
    for (int k = 0; k < 3; k++) begin
      if (xn1_q[k]) begin
        neg_sum = neg_sum + pab1_q[k];
      end else begin
        pos_sum = pos_sum + pab1_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd2_q <= cmd1_q;
    an2_q  <= an1_q;
    for (int k = 0; k < 3; k++) begin
      am2_q[k] <= am1_q[k];
    end
    sa2_q  <= sqa1_q[0] + sqa1_q[1] + sqa1_q[2];
    sb2_q  <= sqb1_q[0] + sqb1_q[1] + sqb1_q[2];
    pos2_q <= pos_sum;
    neg2_q <= neg_sum;
  end

  // square roots, side data delayed alongside
  logic [W-1:0]   len_a, len_b;
  logic [SDW-1:0] side_d, side_q;

  vnc_sqrt_pipe #(.W(W)) u_sqrt_a (.clk_i(clk_i), .sq_i(sa2_q), .root_o(len_a));
  vnc_sqrt_pipe #(.W(W)) u_sqrt_b (.clk_i(clk_i), .sq_i(sb2_q), .root_o(len_b));

  assign side_d = {cmd2_q, an2_q, am2_q[0], am2_q[1], am2_q[2], pos2_q, neg2_q};

  vnc_delay #(.WIDTH(SDW), .DEPTH(W)) u_side_dly (
    .clk_i(clk_i), .d_i(side_d), .q_o(side_q)
  );

  // operand set-up for the dividers
  vnc_pkg::cmd_e  p_cmd;
  logic [2:0]     p_an;
  logic [W-1:0]   p_am [0:2];
  logic [PW-1:0]  p_pos, p_neg, p_dmag;
  logic           p_dneg, za, zb;
  logic [W-1:0]   len_a1, len_b1;
  logic [PW-1:0]  len_prod, p_scalar;
  logic [NW-1:0]  div_num [0:2];
  logic [PW-1:0]  div_den [0:2];
  vnc_pkg::ctrl_t p_ctrl;

  assign {p_cmd, p_an, p_am[0], p_am[1], p_am[2], p_pos, p_neg} = side_q;

  always_comb begin
    p_dneg   = (p_neg > p_pos);
    p_dmag   = p_dneg ? (p_neg - p_pos) : (p_pos - p_neg);
    za       = (len_a == '0);
    zb       = (len_b == '0);
    len_a1   = za ? ONE : len_a;
    len_b1   = zb ? ONE : len_b;
    len_prod = len_a1 * len_b1;

    for (int k = 0; k < 3; k++) begin
      div_num[k] = NW'({p_am[k], {F{1'b0}}});
      div_den[k] = PW'(len_a1);
    end

    p_ctrl.cmd   = p_cmd;
    p_ctrl.a_neg = p_an;
    p_ctrl.d_neg = 1'b0;
    p_ctrl.zero  = 1'b0;
    p_scalar     = '0;

    unique case (p_cmd)
      vnc_pkg::CMD_LENGTH: begin
        p_ctrl.zero = za;
        p_scalar    = PW'(len_a);
      end
      vnc_pkg::CMD_NORMALIZE: begin
        p_ctrl.zero = za;
        p_scalar    = PW'(len_a1);
      end
      vnc_pkg::CMD_DOT: begin
        p_ctrl.d_neg = p_dneg;
        p_scalar     = p_dmag >> F;
      end
      vnc_pkg::CMD_COSINE: begin
        p_ctrl.zero  = za | zb;
        p_ctrl.d_neg = p_dneg;
        div_num[0]   = {p_dmag, {F{1'b0}}};
        div_den[0]   = len_prod;
      end
      default: begin
        p_ctrl.zero = 1'b0;
      end
    endcase
  end

  logic [NW-1:0] quo [0:2];

  for (genvar k = 0; k < 3; k++) begin : g_div
    vnc_div_pipe #(.NW(NW), .DW(PW)) u_div (
      .clk_i(clk_i), .num_i(div_num[k]), .den_i(div_den[k]), .quo_o(quo[k])
    );
  end

  logic [CW+PW-1:0] post_q;
  vnc_pkg::ctrl_t   o_ctrl;
  logic [PW-1:0]    o_scalar;

  vnc_delay #(.WIDTH(CW + PW), .DEPTH(NW + 1)) u_post_dly (
    .clk_i(clk_i), .d_i({p_ctrl, p_scalar}), .q_o(post_q)
  );

  assign {o_ctrl, o_scalar} = post_q;

  // output clipping
  logic [NW-1:0] s_mag;
  logic [W:0]    s_clip;
  logic [W:0]    u_clip [0:2];
  logic          is_norm;

  always_comb begin
    is_norm = (o_ctrl.cmd == vnc_pkg::CMD_NORMALIZE);
    s_mag   = (o_ctrl.cmd == vnc_pkg::CMD_COSINE) ? quo[0] : NW'(o_scalar);
    s_clip  = clip_word(s_mag, o_ctrl.d_neg && (s_mag != '0));
    for (int k = 0; k < 3; k++) begin
      u_clip[k] = clip_word(quo[k], o_ctrl.a_neg[k] && (quo[k] != '0));
    end
  end

  always_ff @(posedge clk_i) begin
    scalar_out_o  <= s_clip[W-1:0];
    saturated_o   <= s_clip[W];
    zero_vector_o <= o_ctrl.zero;
    unit_x_o      <= is_norm ? u_clip[0][W-1:0] : '0;
    unit_y_o      <= is_norm ? u_clip[1][W-1:0] : '0;
    unit_z_o      <= is_norm ? u_clip[2][W-1:0] : '0;
  end

endmodule
